### rtl/lpri_pkg.sv
`timescale 1ns / 1ps

package lpri_pkg;

    localparam int COORD_W      = 16;
    localparam int MAX_RANGE_W  = 15;
    localparam int CODE_W       = 8;
    localparam int ANGLE_W      = 32;
    localparam int CORDIC_W     = 33;
    localparam int CORDIC_STEPS = 28;
    localparam int RANGE_ROOT_W = 24;

    localparam logic [MAX_RANGE_W-1:0] MAX_RANGE_RESET = 15'd8000;

    localparam logic [ANGLE_W-1:0] EIGHTH_TURN  = 32'h2000_0000;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;

    // Rotation angles atan(2^-i) in units of 2^-32 of a turn.
    localparam logic [ANGLE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x_mm;
        logic signed [COORD_W-1:0] y_mm;
        logic signed [COORD_W-1:0] z_mm;
    } point_t;

    typedef struct packed {
        logic [7:0] row;
        logic [8:0] column;
        logic [7:0] range_code;
    } pixel_t;

    typedef struct packed {
        logic zero;
        logic q_zero;
        logic q_eq;
        logic swap;
        logic neg_u;
        logic neg_v;
    } octant_t;

endpackage

### rtl/lpri_isqrt.sv
`timescale 1ns / 1ps

module lpri_isqrt #(
    parameter int IW = 60,
    parameter int SW = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IW-1:0]       in_val,
    input  logic [SW-1:0]       in_side,
    output logic                out_valid,
    output logic [IW/2-1:0]     out_root,
    output logic [SW-1:0]       out_side
);

    localparam int RW = IW / 2;

    logic          valid_reg [RW];
    logic [IW-1:0] rem_reg   [RW];
    logic [RW-1:0] root_reg  [RW];
    logic [SW-1:0] side_reg  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int B = RW - 1 - k;

        logic          valid_in;
        logic [IW-1:0] rem_in;
        logic [RW-1:0] root_in;
        logic [SW-1:0] side_in;
        logic [IW:0]   trial;
        logic          fits;
        logic [IW-1:0] rem_next;
        logic [RW-1:0] root_next;

        if (k == 0) begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_val;
            assign root_in  = '0;
            assign side_in  = in_side;
        end else begin : g_rest
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign side_in  = side_reg[k-1];
        end

        assign trial = ((IW + 1)'(root_in) << (B + 1)) + ((IW + 1)'(1) << (2 * B));
        assign fits  = {1'b0, rem_in} >= trial;

        always_comb
        begin
            rem_next  = rem_in;
            root_next = root_in;
            if (fits)
            begin
                rem_next  = rem_in - trial[IW-1:0];
                root_next = root_in | (RW'(1) << B);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

### rtl/lpri_cordic.sv
`timescale 1ns / 1ps

module lpri_cordic
    import lpri_pkg::*;
#(
    parameter int SW = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic signed [CORDIC_W-1:0] in_u,
    input  logic signed [CORDIC_W-1:0] in_v,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [ANGLE_W-1:0]         out_angle,
    output logic [SW-1:0]              out_side
);

    logic signed [CORDIC_W-1:0] au;
    logic signed [CORDIC_W-1:0] av;
    logic signed [CORDIC_W-1:0] p_next;
    logic signed [CORDIC_W-1:0] q_next;
    octant_t                    oct_next;

    logic                       pre_valid_reg;
    logic signed [CORDIC_W-1:0] pre_x_reg;
    logic signed [CORDIC_W-1:0] pre_y_reg;
    octant_t                    pre_oct_reg;
    logic [SW-1:0]              pre_side_reg;

    logic                       it_valid_reg [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] it_x_reg     [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] it_y_reg     [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] it_z_reg     [CORDIC_STEPS];
    octant_t                    it_oct_reg   [CORDIC_STEPS];
    logic [SW-1:0]              it_side_reg  [CORDIC_STEPS];

    logic signed [CORDIC_W-1:0] z_last;
    octant_t                    oct_last;
    logic [ANGLE_W-1:0]         clamp_a;
    logic [ANGLE_W-1:0]         oct_a;
    logic [ANGLE_W-1:0]         half_a;
    logic [ANGLE_W-1:0]         side_a;
    logic [ANGLE_W-1:0]         angle_next;

    logic                       out_valid_reg;
    logic [ANGLE_W-1:0]         out_angle_reg;
    logic [SW-1:0]              out_side_reg;

    // Fold the vector into the first octant.
    always_comb
    begin
        au              = in_u[CORDIC_W-1] ? -in_u : in_u;
        av              = in_v[CORDIC_W-1] ? -in_v : in_v;
        oct_next.swap   = av > au;
        p_next          = oct_next.swap ? av : au;
        q_next          = oct_next.swap ? au : av;
        oct_next.zero   = (au == '0) && (av == '0);
        oct_next.q_zero = q_next == '0;
        oct_next.q_eq   = q_next == p_next;
        oct_next.neg_u  = in_u[CORDIC_W-1];
        oct_next.neg_v  = in_v[CORDIC_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_x_reg    <= p_next;
            pre_y_reg    <= q_next;
            pre_oct_reg  <= oct_next;
            pre_side_reg <= in_side;
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
        logic                       valid_in;
        logic signed [CORDIC_W-1:0] x_in;
        logic signed [CORDIC_W-1:0] y_in;
        logic signed [CORDIC_W-1:0] z_in;
        octant_t                    oct_in;
        logic [SW-1:0]              side_in;
        logic signed [CORDIC_W-1:0] t_k;
        logic signed [CORDIC_W-1:0] x_next;
        logic signed [CORDIC_W-1:0] y_next;
        logic signed [CORDIC_W-1:0] z_next;

        if (k == 0) begin : g_first
            assign valid_in = pre_valid_reg;
            assign x_in     = pre_x_reg;
            assign y_in     = pre_y_reg;
            assign z_in     = '0;
            assign oct_in   = pre_oct_reg;
            assign side_in  = pre_side_reg;
        end else begin : g_rest
            assign valid_in = it_valid_reg[k-1];
            assign x_in     = it_x_reg[k-1];
            assign y_in     = it_y_reg[k-1];
            assign z_in     = it_z_reg[k-1];
            assign oct_in   = it_oct_reg[k-1];
            assign side_in  = it_side_reg[k-1];
        end

        assign t_k = signed'(CORDIC_W'(ATAN_TURN[k]));

        always_comb
        begin
            if (!y_in[CORDIC_W-1])
            begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + t_k;
            end
            else
            begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - t_k;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                it_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                it_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                it_x_reg[k]    <= x_next;
                it_y_reg[k]    <= y_next;
                it_z_reg[k]    <= z_next;
                it_oct_reg[k]  <= oct_in;
                it_side_reg[k] <= side_in;
            end
        end
    end

    assign z_last   = it_z_reg[CORDIC_STEPS-1];
    assign oct_last = it_oct_reg[CORDIC_STEPS-1];

    // Clamp to the octant, then unfold into the full turn.
    always_comb
    begin
        if (z_last[CORDIC_W-1])
        begin
            clamp_a = '0;
        end
        else if (z_last > signed'(CORDIC_W'(EIGHTH_TURN)))
        begin
            clamp_a = EIGHTH_TURN;
        end
        else
        begin
            clamp_a = z_last[ANGLE_W-1:0];
        end

        if (oct_last.zero || oct_last.q_zero)
        begin
            oct_a = '0;
        end
        else if (oct_last.q_eq)
        begin
            oct_a = EIGHTH_TURN;
        end
        else
        begin
            oct_a = clamp_a;
        end

        side_a     = oct_last.swap  ? QUARTER_TURN - oct_a : oct_a;
        half_a     = oct_last.neg_u ? HALF_TURN - side_a : side_a;
        angle_next = oct_last.neg_v ? '0 - half_a : half_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= it_valid_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_angle_reg <= angle_next;
            out_side_reg  <= it_side_reg[CORDIC_STEPS-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_angle = out_angle_reg;
    assign out_side  = out_side_reg;

endmodule

### rtl/lpri_div.sv
`timescale 1ns / 1ps

module lpri_div
    import lpri_pkg::*;
#(
    parameter int SW = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [RANGE_ROOT_W-1:0] in_root,
    input  logic [MAX_RANGE_W-1:0]  in_max,
    input  logic [SW-1:0]           in_side,
    output logic                    out_valid,
    output logic [CODE_W-1:0]       out_code,
    output logic [SW-1:0]           out_side
);

    logic                    sat_next;

    logic                    s0_valid_reg;
    logic [RANGE_ROOT_W-1:0] s0_rem_reg;
    logic [MAX_RANGE_W-1:0]  s0_max_reg;
    logic                    s0_sat_reg;
    logic [SW-1:0]           s0_side_reg;

    logic                    q_valid_reg [CODE_W];
    logic [RANGE_ROOT_W-1:0] q_rem_reg   [CODE_W];
    logic [CODE_W-1:0]       q_quot_reg  [CODE_W];
    logic [MAX_RANGE_W-1:0]  q_max_reg   [CODE_W];
    logic                    q_sat_reg   [CODE_W];
    logic [SW-1:0]           q_side_reg  [CODE_W];

    // A quotient of 256 or more saturates; a zero divisor always does.
    assign sat_next = in_root >= (RANGE_ROOT_W'(in_max) << CODE_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_rem_reg  <= in_root;
            s0_max_reg  <= in_max;
            s0_sat_reg  <= sat_next;
            s0_side_reg <= in_side;
        end
    end

    for (genvar k = 0; k < CODE_W; k++) begin : g_bit
        localparam int B = CODE_W - 1 - k;

        logic                    valid_in;
        logic [RANGE_ROOT_W-1:0] rem_in;
        logic [CODE_W-1:0]       quot_in;
        logic [MAX_RANGE_W-1:0]  max_in;
        logic                    sat_in;
        logic [SW-1:0]           side_in;
        logic [RANGE_ROOT_W-1:0] divisor;
        logic                    fits;
        logic [RANGE_ROOT_W-1:0] rem_next;
        logic [CODE_W-1:0]       quot_next;

        if (k == 0) begin : g_first
            assign valid_in = s0_valid_reg;
            assign rem_in   = s0_rem_reg;
            assign quot_in  = '0;
            assign max_in   = s0_max_reg;
            assign sat_in   = s0_sat_reg;
            assign side_in  = s0_side_reg;
        end else begin : g_rest
            assign valid_in = q_valid_reg[k-1];
            assign rem_in   = q_rem_reg[k-1];
            assign quot_in  = q_quot_reg[k-1];
            assign max_in   = q_max_reg[k-1];
            assign sat_in   = q_sat_reg[k-1];
            assign side_in  = q_side_reg[k-1];
        end

        assign divisor   = RANGE_ROOT_W'(max_in) << B;
        assign fits      = rem_in >= divisor;
        assign rem_next  = fits ? rem_in - divisor : rem_in;
        assign quot_next = quot_in | (CODE_W'(fits) << B);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                q_valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_rem_reg[k]  <= rem_next;
                q_quot_reg[k] <= quot_next;
                q_max_reg[k]  <= max_in;
                q_sat_reg[k]  <= sat_in;
                q_side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = q_valid_reg[CODE_W-1];
    assign out_code  = q_sat_reg[CODE_W-1] ? '1 : q_quot_reg[CODE_W-1];
    assign out_side  = q_side_reg[CODE_W-1];

endmodule

### rtl/lidar_point_to_range_image_unit.sv
`timescale 1ns / 1ps

// Projects one lidar point per cycle into a pixel write of a spherical range
// image: the column comes from the azimuth, the row from the doubled polar
// angle, and range_code is floor(256 * range / max_range_mm) saturated at 255.
// Every item yields exactly one result, which passes in turn through the three
// input stages, the 30-step square root of the planar radius, the 24-step
// square root of the full range, the 30-stage CORDIC angle pipelines, the
// 9-stage range divider and the output register. The whole pipeline advances
// whenever the output register is empty or being read, so a new item is
// accepted in every cycle in which it advances, and none while it is stalled.
// The configuration port is always ready and max_range_mm resets to 8000.
module lidar_point_to_range_image_unit
    import lpri_pkg::*;
#(
    parameter int ROWS = 200,
    parameter int COLS = 400
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  point_t                 in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output pixel_t                 out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MAX_RANGE_W-1:0] cfg_data
);

    localparam int ROWS_W  = $clog2(ROWS + 1);
    localparam int COLS_W  = $clog2(COLS + 1);
    localparam int RPROD_W = ANGLE_W + ROWS_W;
    localparam int CPROD_W = ANGLE_W + COLS_W;
    localparam int SQ_W    = 2 * COORD_W - 1;
    localparam int SUM_W   = 2 * COORD_W;
    localparam int PLANAR_IN_W = 60;
    localparam int PLANAR_RT_W = PLANAR_IN_W / 2;
    localparam int TOTAL_IN_W  = 2 * RANGE_ROOT_W;
    localparam int SPLIT_W     = RANGE_ROOT_W / 2;
    localparam int SIDE1_W = 3 * COORD_W + SUM_W;
    localparam int SIDE2_W = 3 * COORD_W + PLANAR_RT_W;

    logic                   en;
    logic [MAX_RANGE_W-1:0] max_range_reg;

    logic                   s1_valid_reg;
    point_t                 s1_point_reg;

    logic signed [SUM_W-1:0] x_sq;
    logic signed [SUM_W-1:0] y_sq;
    logic signed [SUM_W-1:0] z_sq;
    logic                    s2_valid_reg;
    point_t                  s2_point_reg;
    logic [SQ_W-1:0]         s2_xx_reg;
    logic [SQ_W-1:0]         s2_yy_reg;
    logic [SQ_W-1:0]         s2_zz_reg;

    logic [SUM_W-1:0]        planar_next;
    logic [SUM_W-1:0]        total_next;
    logic                    s3_valid_reg;
    point_t                  s3_point_reg;
    logic [SUM_W-1:0]        s3_planar_reg;
    logic [SUM_W-1:0]        s3_total_reg;

    logic                    r1_valid;
    logic [PLANAR_RT_W-1:0]  r1_root;
    logic [SIDE1_W-1:0]      r1_side;
    point_t                  r1_point;
    logic [SUM_W-1:0]        r1_total;

    logic                    r2_valid;
    logic [RANGE_ROOT_W-1:0] r2_root;
    logic [SIDE2_W-1:0]      r2_side;
    point_t                  r2_point;
    logic [PLANAR_RT_W-1:0]  r2_planar_root;

    logic signed [CORDIC_W-1:0] az_u;
    logic signed [CORDIC_W-1:0] az_v;
    logic signed [CORDIC_W-1:0] pol_u;
    logic signed [CORDIC_W-1:0] pol_v;
    logic                       az_valid;
    logic [ANGLE_W-1:0]         az_angle;
    logic [SPLIT_W-1:0]         az_side;
    logic                       pol_valid;
    logic [ANGLE_W-1:0]         pol_angle;
    logic [SPLIT_W-1:0]         pol_side;

    logic                    dv_valid;
    logic [CODE_W-1:0]       dv_code;
    logic [2*ANGLE_W-1:0]    dv_side;

    logic [ANGLE_W-1:0]      az_fin;
    logic [ANGLE_W-1:0]      pfrac;
    logic [RPROD_W-1:0]      row_prod;
    logic [CPROD_W-1:0]      col_prod;
    pixel_t                  pixel_next;

    logic                    out_valid_reg;
    pixel_t                  out_data_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_range_reg <= MAX_RANGE_RESET;
        end
        else if (cfg_valid)
        begin
            max_range_reg <= cfg_data;
        end
    end

    // Input register, squares, then planar and total sums.
    assign x_sq = s1_point_reg.x_mm * s1_point_reg.x_mm;
    assign y_sq = s1_point_reg.y_mm * s1_point_reg.y_mm;
    assign z_sq = s1_point_reg.z_mm * s1_point_reg.z_mm;

    assign planar_next = SUM_W'(s2_xx_reg) + SUM_W'(s2_yy_reg);
    assign total_next  = planar_next + SUM_W'(s2_zz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_point_reg  <= in_data;
            s2_point_reg  <= s1_point_reg;
            s2_xx_reg     <= x_sq[SQ_W-1:0];
            s2_yy_reg     <= y_sq[SQ_W-1:0];
            s2_zz_reg     <= z_sq[SQ_W-1:0];
            s3_point_reg  <= s2_point_reg;
            s3_planar_reg <= planar_next;
            s3_total_reg  <= total_next;
        end
    end

    lpri_isqrt #(
        .IW (PLANAR_IN_W),
        .SW (SIDE1_W)
    ) u_planar_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .in_val    ({s3_planar_reg, (PLANAR_IN_W - SUM_W)'(0)}),
        .in_side   ({s3_point_reg, s3_total_reg}),
        .out_valid (r1_valid),
        .out_root  (r1_root),
        .out_side  (r1_side)
    );

    assign {r1_point, r1_total} = r1_side;

    lpri_isqrt #(
        .IW (TOTAL_IN_W),
        .SW (SIDE2_W)
    ) u_range_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r1_valid),
        .in_val    ({r1_total, (TOTAL_IN_W - SUM_W)'(0)}),
        .in_side   ({r1_point, r1_root}),
        .out_valid (r2_valid),
        .out_root  (r2_root),
        .out_side  (r2_side)
    );

    assign {r2_point, r2_planar_root} = r2_side;

    assign az_u  = CORDIC_W'(signed'({r2_point.x_mm, 14'd0}));
    assign az_v  = CORDIC_W'(signed'({r2_point.y_mm, 14'd0}));
    assign pol_u = signed'(CORDIC_W'(r2_planar_root));
    assign pol_v = CORDIC_W'(signed'({r2_point.z_mm, 14'd0}));

    lpri_cordic #(
        .SW (SPLIT_W)
    ) u_azimuth (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r2_valid),
        .in_u      (az_u),
        .in_v      (az_v),
        .in_side   (r2_root[RANGE_ROOT_W-1:SPLIT_W]),
        .out_valid (az_valid),
        .out_angle (az_angle),
        .out_side  (az_side)
    );

    lpri_cordic #(
        .SW (SPLIT_W)
    ) u_polar (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r2_valid),
        .in_u      (pol_u),
        .in_v      (pol_v),
        .in_side   (r2_root[SPLIT_W-1:0]),
        .out_valid (pol_valid),
        .out_angle (pol_angle),
        .out_side  (pol_side)
    );

    lpri_div #(
        .SW (2 * ANGLE_W)
    ) u_range_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (az_valid && pol_valid),
        .in_root   ({az_side, pol_side}),
        .in_max    (max_range_reg),
        .in_side   ({az_angle, pol_angle}),
        .out_valid (dv_valid),
        .out_code  (dv_code),
        .out_side  (dv_side)
    );

    assign {az_fin, pfrac} = {dv_side[2*ANGLE_W-1:ANGLE_W], dv_side[ANGLE_W-2:0], 1'b0};

    assign row_prod = RPROD_W'(pfrac) * RPROD_W'(ROWS);
    assign col_prod = CPROD_W'(az_fin) * CPROD_W'(COLS);

    always_comb
    begin
        pixel_next.row        = 8'(row_prod[RPROD_W-1:ANGLE_W]);
        pixel_next.column     = 9'(col_prod[CPROD_W-1:ANGLE_W]);
        pixel_next.range_code = dv_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= pixel_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/lpri_checker.sv
`timescale 1ns / 1ps

module lpri_checker
    import lpri_pkg::*;
#(
    parameter int ROWS = 200,
    parameter int COLS = 400
) (
    input logic   clk,
    input logic   rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input pixel_t out_data
);

    // A result that is not taken stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed");

    // The pipeline freezes while its output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
    else $error("input item accepted while output is blocked");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ROWS > 256) || (int'(out_data.row) < ROWS))
    else $error("row outside the image");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (COLS > 512) || (int'(out_data.column) < COLS))
    else $error("column outside the image");

endmodule

bind lidar_point_to_range_image_unit lpri_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_lpri_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lpri_pkg::*;

    localparam int ROWS_P = 200;
    localparam int COLS_P = 400;
    localparam int LATENCY = 97;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1100;

    typedef enum int {
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } idle_phase_e;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    point_t in_data;
    logic out_valid;
    logic out_ready;
    pixel_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [MAX_RANGE_W-1:0] cfg_data;

    lidar_point_to_range_image_unit #(
        .ROWS(ROWS_P),
        .COLS(COLS_P)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    pixel_t pending_pixels[$];
    logic [MAX_RANGE_W-1:0] range_scale;
    int mismatch_count;
    int points_sent;
    int pixels_seen;
    int idle_cycles;
    idle_phase_e phase;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_shr(longint v, int n);
        if (v >= 0)
        begin
            return v >>> n;
        end
        return -64'sd1 - ((-64'sd1 - v) >>> n);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint first_octant(longint p, longint q);
        longint cx;
        longint cy;
        longint cz;
        longint xs;
        longint ys;
        cx = p;
        cy = q;
        cz = 0;
        if (q == 0)
        begin
            return 0;
        end
        if (q == p)
        begin
            return longint'(EIGHTH_TURN);
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = floor_shr(cx, i);
            ys = floor_shr(cy, i);
            if (cy >= 0)
            begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + longint'(ATAN_TURN[i]);
            end
            else
            begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - longint'(ATAN_TURN[i]);
            end
        end
        if (cz < 0)
        begin
            cz = 0;
        end
        if (cz > longint'(EIGHTH_TURN))
        begin
            cz = longint'(EIGHTH_TURN);
        end
        return cz;
    endfunction

    function automatic logic [31:0] turn_angle(longint v, longint u);
        longint au;
        longint av;
        logic [31:0] a;
        au = (u < 0) ? -u : u;
        av = (v < 0) ? -v : v;
        if (au == 0 && av == 0)
        begin
            return 32'd0;
        end
        if (av > au)
        begin
            a = 32'(longint'(QUARTER_TURN) - first_octant(av, au));
        end
        else
        begin
            a = 32'(first_octant(au, av));
        end
        if (u < 0)
        begin
            a = HALF_TURN - a;
        end
        if (v < 0)
        begin
            a = 32'd0 - a;
        end
        return a;
    endfunction

    function automatic pixel_t project_point(point_t pt, logic [MAX_RANGE_W-1:0] scale);
        longint x;
        longint y;
        longint z;
        longint unsigned planar;
        longint unsigned total;
        logic [31:0] az;
        logic [31:0] pol;
        logic [31:0] pfrac;
        longint rq;
        longint unsigned code;
        pixel_t px;
        x = longint'(pt.x_mm);
        y = longint'(pt.y_mm);
        z = longint'(pt.z_mm);
        planar = longint'(x * x + y * y);
        total = planar + longint'(z * z);
        az = turn_angle(y * 16384, x * 16384);
        rq = longint'(int_sqrt(planar << 28));
        pol = turn_angle(z * 16384, rq);
        pfrac = pol << 1;
        if (scale == 0)
        begin
            code = 255;
        end
        else
        begin
            code = int_sqrt(total << 16) / longint'(scale);
            if (code > 255)
            begin
                code = 255;
            end
        end
        px.row = 8'((64'(pfrac) * ROWS_P) >> 32);
        px.column = 9'((64'(az) * COLS_P) >> 32);
        px.range_code = 8'(code);
        return px;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("error: pixel %0d %s got %0d expected %0d", pixels_seen, what, got, want);
        mismatch_count++;
    endtask

    function automatic bit send_gap();
        if (phase == PH_SEND_IDLE)
        begin
            return $urandom_range(99) < 83;
        end
        if (phase == PH_BOTH)
        begin
            return $urandom_range(99) < 12;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (phase == PH_RECV_STALL)
        begin
            out_ready <= ($urandom_range(99) >= 83);
        end
        else if (phase == PH_BOTH)
        begin
            out_ready <= ($urandom_range(99) >= 12);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("unexpected", 0, 0);
            end
            else
            begin
                pixel_t want;
                want = pending_pixels.pop_front();
                if (out_data.row !== want.row)
                begin
                    report_mismatch("row", out_data.row, want.row);
                end
                if (out_data.column !== want.column)
                begin
                    report_mismatch("column", out_data.column, want.column);
                end
                if (out_data.range_code !== want.range_code)
                begin
                    report_mismatch("range_code", out_data.range_code, want.range_code);
                end
            end
            pixels_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("lidar_point_to_range_image_unit: mismatch");
            $finish;
        end
    end

    task automatic send_point(point_t pt);
        while (send_gap())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= pt;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_pixels.insert(pending_pixels.size(), project_point(pt, range_scale));
        points_sent++;
    endtask

    task automatic write_range(logic [MAX_RANGE_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        range_scale = value;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic point_t rand_point();
        point_t pt;
        int kind;
        kind = $urandom_range(9);
        pt.x_mm = 16'($urandom);
        pt.y_mm = 16'($urandom);
        pt.z_mm = 16'($urandom);
        if (kind < 4)
        begin
            pt.x_mm = 16'($signed($urandom_range(20000)) - 10000);
            pt.y_mm = 16'($signed($urandom_range(20000)) - 10000);
            pt.z_mm = 16'($signed($urandom_range(4000)) - 2000);
        end
        else if (kind == 4)
        begin
            pt.y_mm = ($urandom_range(1)) ? pt.x_mm : -pt.x_mm;
        end
        else if (kind == 5)
        begin
            pt.x_mm = 16'($signed($urandom_range(20)) - 10);
            pt.y_mm = 16'($signed($urandom_range(20)) - 10);
            pt.z_mm = 16'($signed($urandom_range(20)) - 10);
        end
        else if (kind == 6)
        begin
            pt.y_mm = 16'sd0;
        end
        return pt;
    endfunction

    typedef struct {
        point_t pt;
        bit known;
        pixel_t want;
    } directed_row_t;

    directed_row_t directed_rows[$];
    logic [MAX_RANGE_W-1:0] scale_list[6];

    function automatic directed_row_t mk(int x, int y, int z, bit known,
                                         int r, int c, int code);
        directed_row_t d;
        d.pt.x_mm = 16'(x);
        d.pt.y_mm = 16'(y);
        d.pt.z_mm = 16'(z);
        d.known = known;
        d.want.row = 8'(r);
        d.want.column = 9'(c);
        d.want.range_code = 8'(code);
        return d;
    endfunction

    function automatic void add_row(directed_row_t d);
        directed_rows.insert(directed_rows.size(), d);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatch_count = 0;
        points_sent = 0;
        pixels_seen = 0;
        idle_cycles = 0;
        phase = PH_FREE;
        range_scale = MAX_RANGE_RESET;
        add_row(mk(0, 0, 0, 1, 0, 0, 0));
        add_row(mk(1000, 0, 0, 1, 0, 0, 32));
        add_row(mk(0, 1000, 0, 1, 0, 100, 32));
        add_row(mk(-1000, 0, 0, 1, 0, 200, 32));
        add_row(mk(0, -1000, 0, 1, 0, 300, 32));
        add_row(mk(0, 0, 1000, 1, 100, 0, 32));
        add_row(mk(0, 0, -1000, 1, 100, 0, 32));
        add_row(mk(32767, 0, 0, 1, 0, 0, 255));
        add_row(mk(-32768, 0, 0, 1, 0, 200, 255));
        add_row(mk(500, 500, 0, 1, 0, 50, 22));
        add_row(mk(-500, 500, 0, 0, 0, 0, 0));
        add_row(mk(-500, -500, 0, 0, 0, 0, 0));
        add_row(mk(500, -500, 0, 0, 0, 0, 0));
        add_row(mk(1000, 0, 1000, 0, 0, 0, 0));
        add_row(mk(32767, 32767, 32767, 0, 0, 0, 0));
        add_row(mk(-32768, -32768, -32768, 0, 0, 0, 0));
        add_row(mk(-32768, 32767, -1, 0, 0, 0, 0));
        add_row(mk(1, 2, 3, 0, 0, 0, 0));
        add_row(mk(-1, -1, 1, 0, 0, 0, 0));
        add_row(mk(12345, -6789, 4321, 0, 0, 0, 0));
        scale_list = '{15'd1, 15'd32767, 15'd0, 15'd250, 15'd20000, 15'd8000};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            send_point(directed_rows[i].pt);
            if (directed_rows[i].known)
            begin
                pending_pixels[pending_pixels.size() - 1] = directed_rows[i].want;
            end
        end
        for (int s = 0; s < 6; s++)
        begin
            write_range(scale_list[s]);
            for (int p = 0; p < 4; p++)
            begin
                phase = idle_phase_e'(p);
                for (int n = 0; n < RANDOM_ITEMS / 24; n++)
                begin
                    send_point(rand_point());
                end
                drain();
            end
            phase = PH_FREE;
        end
        drain();
        $display("Sent %0d points over six range scales, including zero and both extremes,",
                 points_sent);
        $display("under free-running, sender-idle, receiver-stall and mixed traffic.");
        if (mismatch_count == 0)
        begin
            $display("lidar_point_to_range_image_unit: match");
        end
        else
        begin
            $display("lidar_point_to_range_image_unit: mismatch");
        end
        $finish;
    end

endmodule

### files.f
rtl/lpri_pkg.sv
rtl/lpri_isqrt.sv
rtl/lpri_cordic.sv
rtl/lpri_div.sv
rtl/lidar_point_to_range_image_unit.sv
rtl/lpri_checker.sv
tb/tb_top.sv
